// ----- rtl/wwsm_pkg.sv -----
// Shared types and fixed widths of the weighted window sum maximum unit.
`default_nettype none

package wwsm_pkg;

    // Widths of the stream fields and of the running sums.
    localparam int SAMPLE_W  = 32;
    localparam int LEN_W     = 11;
    localparam int WS_W      = 42;
    localparam int WT_W      = 52;
    localparam int PROD_W    = SAMPLE_W + LEN_W + 1;
    localparam int OUT_DATA_W = 56;

    // Most negative weighted sum, the starting point of the maximum.
    localparam logic signed [WT_W-1:0] BEST_INIT = {1'b1, {(WT_W-1){1'b0}}};

    // One accepted word as it leaves the front stage.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [LEN_W-1:0]           factor;
        logic                       slide;
        logic                       full;
        logic                       first;
        logic                       last;
    } item_t;

endpackage

`default_nettype wire

// ----- rtl/wwsm_ram.sv -----
// Generic single-write, single-read RAM with registered read data (read-first).
`default_nettype none

module wwsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; a read of the entry being written sees old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/wwsm_front.sv -----
// Accept stage: window length register, delay line pointers, fill count and word tagging.
`default_nettype none

module wwsm_front #(
    parameter int WINDOW_MAX  = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [wwsm_pkg::LEN_W-1:0]           cfg_data,
    input  wire logic                                 in_valid,
    input  wire logic [wwsm_pkg::SAMPLE_W-1:0]        in_sample,
    input  wire logic                                 in_last,
    input  wire logic                                 adv,
    output logic                                      in_ready,
    output logic                                      ram_we,
    output logic      [$clog2(WINDOW_MAX)-1:0]        ram_waddr,
    output logic      [SAMPLE_BITS-1:0]               ram_wdata,
    output logic                                      ram_re,
    output logic      [$clog2(WINDOW_MAX)-1:0]        ram_raddr,
    output logic                                      s1_valid,
    output wwsm_pkg::item_t                           s1_item
);

    localparam int ADDR_W = $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);

    logic [wwsm_pkg::LEN_W-1:0] len_reg;
    logic [ADDR_W-1:0]          wp_reg;
    logic [ADDR_W-1:0]          wp_next;
    logic [CNT_W-1:0]           fc_reg;
    logic [CNT_W-1:0]           fc_next;
    logic                       s1_valid_reg;
    wwsm_pkg::item_t            s1_item_reg;
    wwsm_pkg::item_t            item_next;
    logic [wwsm_pkg::LEN_W-1:0] len_eff;
    logic                       accept;
    logic                       filling;
    logic [31:0]                rd_sum;
    logic [31:0]                rd_wrap;
    logic signed [SAMPLE_BITS-1:0] sample_s;

    assign in_ready = adv;
    assign accept   = in_valid && adv;

    // Effective window length: zero reads as one, long lengths saturate.
    always_comb
    begin
        if (len_reg == '0)
        begin
            len_eff = wwsm_pkg::LEN_W'(1);
        end
        else if (32'(len_reg) > WINDOW_MAX)
        begin
            len_eff = wwsm_pkg::LEN_W'(WINDOW_MAX);
        end
        else
        begin
            len_eff = len_reg;
        end
    end

    assign filling = 32'(fc_reg) < 32'(len_eff);

    // Delay line read address, the entry leaving the window.
    always_comb
    begin
        rd_sum  = 32'(wp_reg) + 32'(WINDOW_MAX) - 32'(len_eff);
        rd_wrap = (rd_sum >= 32'(WINDOW_MAX)) ? rd_sum - 32'(WINDOW_MAX) : rd_sum;
    end

    assign sample_s = in_sample[SAMPLE_BITS-1:0];

    // Tag the word with its multiplier and its place in the stream.
    always_comb
    begin
        item_next.sample = wwsm_pkg::SAMPLE_W'(sample_s);
        item_next.slide  = !filling;
        item_next.first  = (fc_reg == '0);
        item_next.last   = in_last;
        if (filling)
        begin
            item_next.factor = wwsm_pkg::LEN_W'(32'(fc_reg) + 32'd1);
            item_next.full   = (32'(fc_reg) + 32'd1) == 32'(len_eff);
        end
        else
        begin
            item_next.factor = len_eff;
            item_next.full   = 1'b1;
        end
    end

    // Pointer and fill count; both restart after the last word of a stream.
    always_comb
    begin
        wp_next = wp_reg;
        fc_next = fc_reg;
        if (accept)
        begin
            if (in_last)
            begin
                wp_next = '0;
                fc_next = '0;
            end
            else
            begin
                wp_next = (32'(wp_reg) == WINDOW_MAX - 1) ? '0 : wp_reg + 1'b1;
                fc_next = (32'(fc_reg) < WINDOW_MAX) ? fc_reg + 1'b1 : fc_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= wwsm_pkg::LEN_W'(1);
            wp_reg       <= '0;
            fc_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= cfg_data;
            end
            wp_reg <= wp_next;
            fc_reg <= fc_next;
            if (adv)
            begin
                s1_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item_next;
        end
    end

    // Every accepted word is written; the read is issued alongside.
    assign ram_we    = accept;
    assign ram_waddr = wp_reg;
    assign ram_wdata = in_sample[SAMPLE_BITS-1:0];
    assign ram_re    = accept;
    assign ram_raddr = ADDR_W'(rd_wrap);
    assign s1_valid  = s1_valid_reg;
    assign s1_item   = s1_item_reg;

endmodule

`default_nettype wire

// ----- rtl/wwsm_accum.sv -----
// Multiply, running sums, running maximum and the output register.
`default_nettype none

module wwsm_accum #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s1_valid,
    input  wire wwsm_pkg::item_t                       s1_item,
    input  wire logic [SAMPLE_BITS-1:0]                old_raw,
    input  wire logic                                  out_ready,
    output logic                                       adv,
    output logic                                       out_valid,
    output logic      [wwsm_pkg::WT_W-1:0]             out_best,
    output logic                                       out_found
);

    localparam int WS_W   = wwsm_pkg::WS_W;
    localparam int WT_W   = wwsm_pkg::WT_W;
    localparam int PROD_W = wwsm_pkg::PROD_W;

    logic signed [SAMPLE_BITS-1:0] old_s;
    logic signed [PROD_W-1:0]      prod;

    logic                          s2_valid_reg;
    wwsm_pkg::item_t               s2_item_reg;
    logic signed [PROD_W-1:0]      s2_prod_reg;
    logic signed [wwsm_pkg::SAMPLE_W-1:0] s2_old_reg;

    logic signed [WS_W-1:0]        ws_reg;
    logic signed [WS_W-1:0]        ws_next;
    logic signed [WT_W-1:0]        wt_reg;
    logic signed [WT_W-1:0]        wt_next;
    logic signed [WS_W-1:0]        ws_base;
    logic signed [WT_W-1:0]        wt_base;

    logic                          s3_valid_reg;
    logic                          s3_full_reg;
    logic                          s3_first_reg;
    logic                          s3_last_reg;

    logic signed [WT_W-1:0]        best_reg;
    logic signed [WT_W-1:0]        best_next;
    logic                          hb_reg;
    logic                          hb_next;
    logic signed [WT_W-1:0]        best_base;
    logic                          hb_base;

    logic                          out_valid_reg;
    logic [WT_W-1:0]               out_best_reg;
    logic                          out_found_reg;

    // The whole pipe moves unless a result waits that nobody takes.
    assign adv = !out_valid_reg || out_ready;

    // Stage one: weight times sample.
    assign old_s = old_raw;
    assign prod  = $signed({1'b0, s1_item.factor}) * PROD_W'(s1_item.sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_item_reg <= s1_item;
            s2_prod_reg <= prod;
            s2_old_reg  <= wwsm_pkg::SAMPLE_W'(old_s);
        end
    end

    // Stage two: update the plain and weighted window sums; a new stream starts from zero.
    always_comb
    begin
        ws_base = s2_item_reg.first ? '0 : ws_reg;
        wt_base = s2_item_reg.first ? '0 : wt_reg;
        if (s2_item_reg.slide)
        begin
            wt_next = wt_base + WT_W'(s2_prod_reg) - WT_W'(ws_base);
            ws_next = ws_base + WS_W'(s2_item_reg.sample) - WS_W'(s2_old_reg);
        end
        else
        begin
            wt_next = wt_base + WT_W'(s2_prod_reg);
            ws_next = ws_base + WS_W'(s2_item_reg.sample);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg       <= '0;
            wt_reg       <= '0;
            s3_full_reg  <= 1'b0;
            s3_first_reg <= 1'b0;
            s3_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            if (s2_valid_reg)
            begin
                ws_reg <= ws_next;
                wt_reg <= wt_next;
            end
            s3_full_reg  <= s2_item_reg.full;
            s3_first_reg <= s2_item_reg.first;
            s3_last_reg  <= s2_item_reg.last;
        end
    end

    // Stage three: keep the largest weighted sum of full windows.
    always_comb
    begin
        best_base = s3_first_reg ? wwsm_pkg::BEST_INIT : best_reg;
        hb_base   = s3_first_reg ? 1'b0 : hb_reg;
        best_next = best_base;
        hb_next   = hb_base;
        if (s3_full_reg)
        begin
            if (!hb_base || (wt_reg > best_base))
            begin
                best_next = wt_reg;
            end
            hb_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg      <= wwsm_pkg::BEST_INIT;
            hb_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv && s3_valid_reg)
            begin
                best_reg <= best_next;
                hb_reg   <= hb_next;
            end
            if (adv)
            begin
                out_valid_reg <= s3_valid_reg && s3_last_reg;
            end
        end
    end

    // Output register: the maximum, or zero when no window was completed.
    always_ff @(posedge clk)
    begin
        if (adv && s3_valid_reg && s3_last_reg)
        begin
            out_best_reg  <= hb_next ? best_next : '0;
            out_found_reg <= hb_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_best  = out_best_reg;
    assign out_found = out_found_reg;

endmodule

`default_nettype wire

// ----- rtl/weighted_window_sum_max_unit.sv -----
// The last sample word passes the front, stage two and stage three registers before its result is output.
// Throughput: one sample word per cycle while not stalled, set by the delay line RAM (one read, one write).
// The pipe stalls as a whole only while a result waits at the output unaccepted.
// Reset clears the window length to one and all stream state; the delay line RAM
// is not cleared, since only entries written within the current stream are read.
`default_nettype none

module weighted_window_sum_max_unit #(
    parameter int WINDOW_MAX  = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_data,       // window_len
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // sample [31:0]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [55:0] m_axis_tdata,   // best_sum [51:0], zeros [55:52]
    output logic             m_axis_tuser    // found [0]
);

    localparam int ADDR_W = $clog2(WINDOW_MAX);

    logic                          adv;
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [SAMPLE_BITS-1:0]        ram_wdata;
    logic                          ram_re;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic                          s1_valid;
    wwsm_pkg::item_t               s1_item;
    logic [wwsm_pkg::WT_W-1:0]     best_sum;

    // Front stage: configuration, pointers and tagging.
    wwsm_front #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_sample (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .adv       (adv),
        .in_ready  (s_axis_tready),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .s1_valid  (s1_valid),
        .s1_item   (s1_item)
    );

    // Delay line of past samples.
    wwsm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_delay (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Arithmetic back end and output register.
    wwsm_accum #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_item   (s1_item),
        .old_raw   (ram_rdata),
        .out_ready (m_axis_tready),
        .adv       (adv),
        .out_valid (m_axis_tvalid),
        .out_best  (best_sum),
        .out_found (m_axis_tuser)
    );

    assign m_axis_tdata = wwsm_pkg::OUT_DATA_W'(best_sum);

endmodule

`default_nettype wire

// ----- tb/tb_weighted_window_sum_max_unit.sv -----
// Self-checking stream testbench for the weighted window sum maximum unit.

module tb_weighted_window_sum_max_unit;

    localparam int WINDOW_LEN_MAX = 1024;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct {
        logic [wwsm_pkg::SAMPLE_W-1:0] sample;
        logic                          last;
    } sample_word_t;

    typedef struct {
        logic signed [wwsm_pkg::WT_W-1:0] best_sum;
        logic                             found;
    } max_report_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [wwsm_pkg::LEN_W-1:0] cfg_data = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [31:0]                s_axis_tdata = '0;
    logic                       s_axis_tlast = 1'b0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [55:0]                m_axis_tdata;
    logic                       m_axis_tuser;

    // Words waiting to be sent, and maxima expected back.
    sample_word_t sample_queue[$];
    max_report_t  pending_reports[$];

    sample_word_t cur_word;
    int           src_gap = 0;
    int           sink_wait = 0;
    int           queued_items = 0;
    bit           calm = 1'b0;
    bit           failed = 1'b0;

    // Shadow of the window length register and of the stream state.
    logic [wwsm_pkg::LEN_W-1:0]           win_len = 11'd1;
    logic signed [wwsm_pkg::SAMPLE_W-1:0] delay_mem [WINDOW_LEN_MAX];
    logic [9:0]                           wr_ptr = '0;
    logic [wwsm_pkg::LEN_W-1:0]           fill_cnt = '0;
    logic signed [wwsm_pkg::WS_W-1:0]     win_sum = '0;
    logic signed [wwsm_pkg::WT_W-1:0]     wt_sum = '0;
    logic signed [wwsm_pkg::WT_W-1:0]     best_wt = wwsm_pkg::BEST_INIT;
    bit                                   have_best = 1'b0;

    weighted_window_sum_max_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Hard limit on the run, well beyond the slowest legal schedule.
    initial
    begin
        #(8 * 400_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    // Mostly full-range values, with the extremes and small magnitudes mixed in.
    function automatic logic [wwsm_pkg::SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 15);
            3: return -$urandom_range(1, 16);
            default: return $urandom();
        endcase
    endfunction

    // Advance the shadow stream by one sample and, on the last one, record the maximum.
    task automatic advance_window_sums(input sample_word_t word);
        logic signed [wwsm_pkg::SAMPLE_W-1:0] x;
        logic [wwsm_pkg::LEN_W-1:0]           eff;
        logic [9:0]                           rd;
        bit                                   full;
        longint                               acc;
        max_report_t                          rep;
        x = word.sample;
        if (win_len == 0)
            eff = 11'd1;
        else if (win_len > WINDOW_LEN_MAX)
            eff = wwsm_pkg::LEN_W'(WINDOW_LEN_MAX);
        else
            eff = win_len;

        if (fill_cnt < eff)
        begin
            // Still filling: add the sample with weight equal to its position.
            acc = longint'(wt_sum) + (longint'(fill_cnt) + 1) * longint'(x);
            wt_sum = acc[wwsm_pkg::WT_W-1:0];
            acc = longint'(win_sum) + longint'(x);
            win_sum = acc[wwsm_pkg::WS_W-1:0];
            full = (fill_cnt + 1 == eff);
        end
        else
        begin
            // Sliding: shift every weight down by one and drop the oldest sample.
            rd = wr_ptr - eff[9:0];
            acc = longint'(wt_sum) + longint'(eff) * longint'(x) - longint'(win_sum);
            wt_sum = acc[wwsm_pkg::WT_W-1:0];
            acc = longint'(win_sum) + longint'(x) - longint'(delay_mem[rd]);
            win_sum = acc[wwsm_pkg::WS_W-1:0];
            full = 1'b1;
        end

        delay_mem[wr_ptr] = x;
        wr_ptr = wr_ptr + 1'b1;
        if (fill_cnt < WINDOW_LEN_MAX)
            fill_cnt = fill_cnt + 1'b1;

        if (full)
        begin
            if (!have_best || wt_sum > best_wt)
                best_wt = wt_sum;
            have_best = 1'b1;
        end

        if (word.last)
        begin
            rep.best_sum = have_best ? best_wt : '0;
            rep.found    = have_best;
            pending_reports.push_back(rep);
            wr_ptr    = '0;
            fill_cnt  = '0;
            win_sum   = '0;
            wt_sum    = '0;
            best_wt   = wwsm_pkg::BEST_INIT;
            have_best = 1'b0;
        end
    endtask

    // Source side: present queued words, with a random pause before each one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_window_sums(cur_word);
                src_gap = draw_gap();
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0 || sample_queue.size() == 0)
                begin
                    if (src_gap > 0)
                        src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    cur_word = sample_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cur_word.sample;
                    s_axis_tlast  <= cur_word.last;
                end
            end
        end
    end

    // Sink side: hold off each result word for a random number of cycles, then check it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_wait = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("result word with no maximum expected");
                    failed = 1'b1;
                end
                else
                begin
                    max_report_t exp_rep;
                    exp_rep = pending_reports.pop_front();
                    if (m_axis_tdata[wwsm_pkg::WT_W-1:0] !== exp_rep.best_sum)
                    begin
                        $error("best_sum: expected %0d, got %0d", exp_rep.best_sum,
                               $signed(m_axis_tdata[wwsm_pkg::WT_W-1:0]));
                        failed = 1'b1;
                    end
                    if (m_axis_tuser !== exp_rep.found)
                    begin
                        $error("found: expected %0b, got %0b", exp_rep.found, m_axis_tuser);
                        failed = 1'b1;
                    end
                end
                sink_wait = draw_gap();
            end
            else if (m_axis_tvalid && sink_wait > 0)
                sink_wait--;
            m_axis_tready <= (sink_wait == 0);
        end
    end

    task automatic push_word(input logic [wwsm_pkg::SAMPLE_W-1:0] value, input logic is_last);
        sample_word_t w;
        w.sample = value;
        w.last   = is_last;
        sample_queue.push_back(w);
        queued_items++;
    endtask

    task automatic queue_random_stream(input int count, input bit closes);
        for (int i = 0; i < count; i++)
            push_word(random_sample(), closes && (i == count - 1));
    endtask

    // Write the window length while the unit is idle.
    task automatic set_window_len(input logic [wwsm_pkg::LEN_W-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        win_len = value;
        @(negedge clk);
    endtask

    // Wait until every word has gone in and every maximum has come out,
    // then let the pipe drain any words that produce no result.
    task automatic settle();
        do
            @(negedge clk);
        while (sample_queue.size() != 0 || s_axis_tvalid || pending_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int len;
        int eff_len;
        int n;
        int streams;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Window of one after reset: each sample is its own window; extremes of the sample.
        push_word(32'h7FFF_FFFF, 1'b0);
        push_word(32'h8000_0000, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b1);
        // One-word stream holding the most negative sample.
        push_word(32'h8000_0000, 1'b1);
        settle();

        // Stream shorter than the window reports nothing found.
        set_window_len(11'd4);
        push_word(32'd5, 1'b0);
        push_word(-32'sd3, 1'b1);
        settle();

        // A zero length behaves as a window of one.
        set_window_len(11'd0);
        push_word(32'd7, 1'b0);
        push_word(-32'sd9, 1'b0);
        push_word(32'd2, 1'b1);
        settle();

        // Length raised mid-stream above the fill level: back to filling.
        set_window_len(11'd3);
        push_word(32'd1, 1'b0);
        push_word(32'd2, 1'b0);
        push_word(32'd3, 1'b0);
        push_word(-32'sd4, 1'b0);
        push_word(32'd5, 1'b0);
        settle();
        set_window_len(11'd6);
        push_word(32'd6, 1'b0);
        push_word(-32'sd7, 1'b0);
        push_word(32'd8, 1'b1);
        settle();

        // Length cut mid-stream below the fill level: goes from filling straight to sliding.
        push_word(32'd10, 1'b0);
        push_word(32'd20, 1'b0);
        push_word(-32'sd30, 1'b0);
        push_word(32'd40, 1'b0);
        settle();
        set_window_len(11'd2);
        push_word(32'd50, 1'b0);
        push_word(-32'sd60, 1'b0);
        push_word(32'd70, 1'b1);
        settle();

        // Longest window, reached through saturation of an oversized length;
        // the stream runs past the delay line so the pointer wraps.
        calm = 1'b1;
        set_window_len(11'h7FF);
        queue_random_stream(1040, 1'b1);
        settle();
        set_window_len(11'd1024);
        queue_random_stream(20, 1'b1);
        settle();

        // Random phases: a new length, then a few streams, sometimes left open.
        while (queued_items < 1250)
        begin
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0: len = 0;
                1: len = 1;
                2: len = $urandom_range(17, 64);
                default: len = $urandom_range(2, 16);
            endcase
            set_window_len(wwsm_pkg::LEN_W'(len));
            eff_len = (len == 0) ? 1 : len;
            streams = $urandom_range(1, 3);
            for (int s = 0; s < streams; s++)
            begin
                n = $urandom_range(1, 2 * eff_len + 3);
                queue_random_stream(n, !(s == streams - 1 && $urandom_range(0, 5) == 0));
            end
            settle();
        end

        // Close any stream left open by the last phase.
        push_word(random_sample(), 1'b1);
        settle();

        if (!failed)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- weighted_window_sum_max_unit.f -----
rtl/wwsm_pkg.sv
rtl/wwsm_ram.sv
rtl/wwsm_front.sv
rtl/wwsm_accum.sv
rtl/weighted_window_sum_max_unit.sv
tb/tb_weighted_window_sum_max_unit.sv
